// File: sv/lie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// List intersection engine package
// Types and fixed codes shared by the front queue, the engine and the top.
// ----------------------------------------------------------------------------
package lie_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_RESULTS = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_APPEND_A  = 2'd0;
    localparam logic [1:0] KIND_APPEND_B  = 2'd1;
    localparam logic [1:0] KIND_INTERSECT = 2'd2;

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_FULL     = 2'd1,
        ST_VALUE    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_APPEND_A  = 2'd0,
        OP_APPEND_B  = 2'd1,
        OP_INTERSECT = 2'd2
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_RD,
        S_B_RD,
        S_B_CMP,
        S_E_RD,
        S_E_CMP,
        S_FINISH
    } eng_state_t;

endpackage : lie_pkg
`default_nettype wire

// File: sv/lie_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// List intersection engine front queue
// Accepts input items, decodes their kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module lie_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [1:0]                        kind,
    input  wire logic signed [lie_pkg::VALUE_W-1:0] value,
    output logic                                   cmd_valid,
    output lie_pkg::cmd_t                          cmd,
    input  wire logic                              cmd_take
);
    import lie_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             decode_ok;
    op_t              decode_op;
    logic             wr_en;
    logic             rd_en;

    always_comb
    begin
        decode_ok = 1'b1;
        decode_op = OP_APPEND_A;
        case (kind)
            KIND_APPEND_A:  decode_op = OP_APPEND_A;
            KIND_APPEND_B:  decode_op = OP_APPEND_B;
            KIND_INTERSECT: decode_op = OP_INTERSECT;
            default:        decode_ok = 1'b0;
        endcase
    end

    // A reserved kind is accepted and then discarded.
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign wr_en     = push && !full && decode_ok;
    assign cmd_valid = (count_reg != '0);
    assign rd_en     = cmd_take && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= '{op: decode_op, value: value};
        end
    end

endmodule : lie_front
`default_nettype wire

// File: sv/lie_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// List intersection engine back end
// Stores both lists, runs the nested-loop scan and holds the result register.
// ----------------------------------------------------------------------------
module lie_back #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    input  wire lie_pkg::cmd_t                      cmd,
    output logic                                    cmd_take,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [1:0]                              status,
    output logic signed [lie_pkg::VALUE_W-1:0]      result_value,
    output logic                                    last
);
    import lie_pkg::*;

    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int EMIT_DEPTH = (LIST_DEPTH < MAX_RESULTS) ? LIST_DEPTH : MAX_RESULTS;
    localparam int EIDX_W     = (EMIT_DEPTH > 1) ? $clog2(EMIT_DEPTH) : 1;
    localparam int ECNT_W     = $clog2(EMIT_DEPTH + 1);

    logic [VALUE_W-1:0] a_mem [LIST_DEPTH];
    logic [VALUE_W-1:0] b_mem [LIST_DEPTH];
    logic [VALUE_W-1:0] e_mem [EMIT_DEPTH];
    logic [VALUE_W-1:0] a_rdata_reg;
    logic [VALUE_W-1:0] b_rdata_reg;
    logic [VALUE_W-1:0] e_rdata_reg;

    eng_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   a_count_reg, a_count_next;
    logic [CNT_W-1:0]   b_count_reg, b_count_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [ECNT_W-1:0]  k_reg, k_next;
    logic [ECNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [VALUE_W-1:0] pend_value_reg, pend_value_next;
    logic               out_valid_reg;
    status_t            out_status_reg, out_status_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic slot_free;
    logic out_load;
    logic a_we;
    logic b_we;
    logic e_we;
    logic a_done;
    logic b_done;
    logic e_done;
    logic a_full;
    logic b_full;

    assign slot_free = !out_valid_reg || pop;
    assign a_done    = (i_reg >= a_count_reg) || (emit_cnt_reg == ECNT_W'(EMIT_DEPTH));
    assign b_done    = (j_reg >= b_count_reg);
    assign e_done    = (k_reg >= emit_cnt_reg);
    assign a_full    = (a_count_reg == CNT_W'(LIST_DEPTH));
    assign b_full    = (b_count_reg == CNT_W'(LIST_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_INTERSECT)
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                state_next = a_done ? S_FINISH : S_B_RD;
            end
            S_B_RD:
            begin
                state_next = b_done ? S_A_RD : S_B_CMP;
            end
            S_B_CMP:
            begin
                state_next = (b_rdata_reg == a_rdata_reg) ? S_E_RD : S_B_RD;
            end
            S_E_RD:
            begin
                if (!e_done)
                begin
                    state_next = S_E_CMP;
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    state_next = S_A_RD;
                end
            end
            S_E_CMP:
            begin
                state_next = (e_rdata_reg == a_rdata_reg) ? S_A_RD : S_E_RD;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_take        = 1'b0;
        out_load        = 1'b0;
        a_we            = 1'b0;
        b_we            = 1'b0;
        e_we            = 1'b0;
        a_count_next    = a_count_reg;
        b_count_next    = b_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        out_status_next = ST_EMPTY;
        out_value_next  = '0;
        out_last_next   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_APPEND_A:
                        begin
                            if (slot_free)
                            begin
                                cmd_take = 1'b1;
                                out_load = 1'b1;
                                if (a_full)
                                begin
                                    out_status_next = ST_FULL;
                                end
                                else
                                begin
                                    a_we            = 1'b1;
                                    a_count_next    = a_count_reg + 1'b1;
                                    out_status_next = ST_APPENDED;
                                end
                            end
                        end
                        OP_APPEND_B:
                        begin
                            if (slot_free)
                            begin
                                cmd_take = 1'b1;
                                out_load = 1'b1;
                                if (b_full)
                                begin
                                    out_status_next = ST_FULL;
                                end
                                else
                                begin
                                    b_we            = 1'b1;
                                    b_count_next    = b_count_reg + 1'b1;
                                    out_status_next = ST_APPENDED;
                                end
                            end
                        end
                        OP_INTERSECT:
                        begin
                            cmd_take        = 1'b1;
                            i_next          = '0;
                            emit_cnt_next   = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            S_A_RD:
            begin
                j_next = '0;
            end
            S_B_RD:
            begin
                if (b_done)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_B_CMP:
            begin
                if (b_rdata_reg == a_rdata_reg)
                begin
                    k_next = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_E_RD:
            begin
                if (e_done && (!pend_valid_reg || slot_free))
                begin
                    e_we            = 1'b1;
                    emit_cnt_next   = emit_cnt_reg + 1'b1;
                    i_next          = i_reg + 1'b1;
                    out_load        = pend_valid_reg;
                    out_status_next = ST_VALUE;
                    out_value_next  = pend_value_reg;
                    out_last_next   = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_value_next = a_rdata_reg;
                end
            end
            S_E_CMP:
            begin
                if (e_rdata_reg == a_rdata_reg)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = pend_valid_reg ? ST_VALUE : ST_EMPTY;
                    out_value_next  = pend_valid_reg ? pend_value_reg : '0;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
                cmd_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            a_count_reg    <= '0;
            b_count_reg    <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            a_count_reg    <= a_count_next;
            b_count_reg    <= b_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_count_reg[IDX_W-1:0]] <= cmd.value;
        end
        a_rdata_reg <= a_mem[i_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_count_reg[IDX_W-1:0]] <= cmd.value;
        end
        b_rdata_reg <= b_mem[j_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            e_mem[emit_cnt_reg[EIDX_W-1:0]] <= a_rdata_reg;
        end
        e_rdata_reg <= e_mem[k_reg[EIDX_W-1:0]];
    end

    assign empty        = !out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;
    assign last         = out_last_reg;

endmodule : lie_back
`default_nettype wire

// File: sv/list_intersection_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// List intersection engine
// Two bounded lists of signed values with append and nested-loop intersect.
// ----------------------------------------------------------------------------
// Items enter through a queue port: an item is taken when push is high and
// full is low. Kind 0 appends value to list A, kind 1 to list B, kind 2
// intersects the lists; kind 3 is taken and discarded without a result.
// Results leave through a second queue port: the oldest result is shown while
// empty is low and is taken when pop is high. Each append gives one result;
// an intersect gives one result per distinct common value, up to MAX_RESULTS,
// in list A order, with last set on the final one, or a single empty-marked result.
// An append's result is registered when the engine takes the item from the queue,
// and appends follow at one per cycle while results are taken. An intersect
// scans list A against list B through the engine's single read port on each
// list, with a read state before each compare state.
// A two-item queue between the decoder and the engine keeps input open while
// a scan runs. When pop stays low, the engine holds its result register and
// stops, and the input queue fills and raises full. Reset empties both lists,
// the queue and the result register; list storage itself is not cleared.
// ----------------------------------------------------------------------------
module list_intersection_engine_top #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [1:0]                         kind,
    input  wire logic signed [lie_pkg::VALUE_W-1:0] value,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [1:0]                              status,
    output logic signed [lie_pkg::VALUE_W-1:0]      result_value,
    output logic                                    last
);
    import lie_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    lie_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    lie_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .result_value (result_value),
        .last         (last)
    );

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("engine took an item from an empty queue");

    a_value_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_VALUE) |-> (result_value == '0))
        else $error("non-value result carries a nonzero value");

    a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_APPENDED || status == ST_FULL || status == ST_EMPTY))
        |-> last)
        else $error("single result of an item is not marked last");

endmodule : list_intersection_engine_top
`default_nettype wire
